>>> src/pixel_tone_saturation_threshold_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel tone, saturation and threshold core
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TONE_SATURATION_THRESHOLD_CORE_MACROS_SVH
`define PIXEL_TONE_SATURATION_THRESHOLD_CORE_MACROS_SVH

// Checks a property on every clock edge while reset is released.
`define PTST_ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Checks a property on every clock edge, reset cycles included.
`define PTST_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

>>> src/ptst_pkg.sv
// ----------------------------------------------------------------------------
// ptst_pkg
// Types, register indexes and the shared luma function of the pixel tone,
// saturation and threshold core.
// ----------------------------------------------------------------------------
package ptst_pkg;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Number of registered stages from the input up to and including the output register.
    localparam int PIPE_DEPTH = 7;

    // Channel lanes of one pixel.
    localparam int NUM_CH   = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRAY_ENABLE       = 3'd0,
        REG_CONTRAST_GAIN     = 3'd1,
        REG_BRIGHTNESS_OFFSET = 3'd2,
        REG_SATURATION_FACTOR = 3'd3,
        REG_THRESHOLD_ENABLE  = 3'd4,
        REG_THRESHOLD_LEVEL   = 3'd5,
        REG_INVERT_ENABLE     = 3'd6
    } cfg_reg_index_t;

    // Input and result items.
    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } pixel_out_t;

    // One pixel as an array of channels, indexed by the CH_* constants.
    typedef logic [NUM_CH-1:0][7:0] pix_t;

    // Luma: (1868*B + 9617*G + 4899*R + 8192) >> 14.
    function automatic logic [7:0] luma(input pix_t px);
        logic [21:0] acc;
        acc = 22'(px[CH_BLUE]) * 22'd1868 + 22'(px[CH_GREEN]) * 22'd9617
            + 22'(px[CH_RED]) * 22'd4899 + 22'd8192;
        return acc[21:14];
    endfunction

endpackage

>>> src/pixel_tone_saturation_threshold_core.sv
// Registers in item order: gray, tone product, tone, merge, sat product, sat, output.
// Throughput: 1 item per cycle; all stages advance together whenever the
// output register is empty or being taken, and s_ready follows that.
// Three channel lanes run tone and saturation side by side, one multiplier each per phase.
// Reset (aresetn low, synchronous) empties the pipeline and loads default registers.
// ----------------------------------------------------------------------------
// pixel_tone_saturation_threshold_core
// Per-pixel grayscale, contrast/brightness, saturation, threshold and invert
// on a valid/ready stream with a plain configuration write port.
// ----------------------------------------------------------------------------
module pixel_tone_saturation_threshold_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_en,
    input  logic [ptst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptst_pkg::CFG_DATA_W-1:0]     cfg_write_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ptst_pkg::pixel_in_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ptst_pkg::pixel_out_t                m_data
);

    logic               gray_enable_reg;
    logic [9:0]         contrast_gain_reg;
    logic signed [12:0] brightness_offset_reg;
    logic [9:0]         saturation_factor_reg;
    logic               threshold_enable_reg;
    logic [7:0]         threshold_level_reg;
    logic               invert_enable_reg;

    logic [ptst_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic                            advance;

    ptst_pkg::pix_t in_pix;
    ptst_pkg::pix_t gray_pix_next;
    ptst_pkg::pix_t gray_pix_reg;
    ptst_pkg::pix_t tone_pix;
    ptst_pkg::pix_t tone_merged_reg;
    logic [7:0]     tone_luma_reg;
    ptst_pkg::pix_t sat_pix;
    ptst_pkg::pix_t final_pix;
    logic [7:0]     in_luma;
    logic [7:0]     sat_luma;
    ptst_pkg::pixel_out_t out_next;
    ptst_pkg::pixel_out_t out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_enable_reg       <= 1'b0;
            contrast_gain_reg     <= 10'd256;
            brightness_offset_reg <= 13'sd0;
            saturation_factor_reg <= 10'd256;
            threshold_enable_reg  <= 1'b0;
            threshold_level_reg   <= 8'd0;
            invert_enable_reg     <= 1'b0;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                ptst_pkg::REG_GRAY_ENABLE:       gray_enable_reg <= cfg_write_data[0];
                ptst_pkg::REG_CONTRAST_GAIN:     contrast_gain_reg <= cfg_write_data[9:0];
                ptst_pkg::REG_BRIGHTNESS_OFFSET: brightness_offset_reg <= $signed(cfg_write_data);
                ptst_pkg::REG_SATURATION_FACTOR: saturation_factor_reg <= cfg_write_data[9:0];
                ptst_pkg::REG_THRESHOLD_ENABLE:  threshold_enable_reg <= cfg_write_data[0];
                ptst_pkg::REG_THRESHOLD_LEVEL:   threshold_level_reg <= cfg_write_data[7:0];
                ptst_pkg::REG_INVERT_ENABLE:     invert_enable_reg <= cfg_write_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage control: everything moves when the output register can take an item.
    assign advance = !valid_reg[ptst_pkg::PIPE_DEPTH-1] || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[ptst_pkg::PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Input stage with optional grayscale.
    always_comb begin
        in_pix[ptst_pkg::CH_BLUE]  = s_data.blue_in;
        in_pix[ptst_pkg::CH_GREEN] = s_data.green_in;
        in_pix[ptst_pkg::CH_RED]   = s_data.red_in;
        in_luma = ptst_pkg::luma(in_pix);
        if (gray_enable_reg) begin
            gray_pix_next = {ptst_pkg::NUM_CH{in_luma}};
        end else begin
            gray_pix_next = in_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gray_pix_reg <= gray_pix_next;
        end
    end

    // Tone lanes, merge with luma, then saturation lanes.
    for (genvar c = 0; c < ptst_pkg::NUM_CH; c++) begin : g_tone
        ptst_tone_lane u_tone (
            .aclk              (aclk),
            .advance           (advance),
            .value             (gray_pix_reg[c]),
            .contrast_gain     (contrast_gain_reg),
            .brightness_offset (brightness_offset_reg),
            .tone_reg          (tone_pix[c])
        );
    end

    ptst_luma_merge u_merge (
        .aclk      (aclk),
        .advance   (advance),
        .pixel     (tone_pix),
        .pixel_reg (tone_merged_reg),
        .luma_reg  (tone_luma_reg)
    );

    for (genvar c = 0; c < ptst_pkg::NUM_CH; c++) begin : g_sat
        ptst_sat_lane u_sat (
            .aclk              (aclk),
            .advance           (advance),
            .value             (tone_merged_reg[c]),
            .luma_value        (tone_luma_reg),
            .saturation_factor (saturation_factor_reg),
            .sat_reg           (sat_pix[c])
        );
    end

    // Final merge: threshold on luma, optional invert, output register.
    always_comb begin
        sat_luma = ptst_pkg::luma(sat_pix);
        if (threshold_enable_reg) begin
            final_pix = {ptst_pkg::NUM_CH{(sat_luma > threshold_level_reg) ? 8'd255 : 8'd0}};
        end else begin
            final_pix = sat_pix;
        end
        if (invert_enable_reg) begin
            final_pix = ~final_pix;
        end
        out_next.blue_out  = final_pix[ptst_pkg::CH_BLUE];
        out_next.green_out = final_pix[ptst_pkg::CH_GREEN];
        out_next.red_out   = final_pix[ptst_pkg::CH_RED];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = valid_reg[ptst_pkg::PIPE_DEPTH-1];
    assign m_data  = out_reg;

endmodule

>>> src/ptst_tone_lane.sv
// ----------------------------------------------------------------------------
// ptst_tone_lane
// Contrast and brightness for one channel: a registered multiply by the gain,
// then a registered round-half-even and clamp to 0..255.
// ----------------------------------------------------------------------------
module ptst_tone_lane (
    input  logic               aclk,
    input  logic               advance,
    input  logic [7:0]         value,
    input  logic [9:0]         contrast_gain,
    input  logic signed [12:0] brightness_offset,
    output logic [7:0]         tone_reg
);

    logic signed [9:0]  centered;
    logic signed [20:0] prod_next;
    logic signed [20:0] prod_reg;
    logic signed [25:0] num;
    logic signed [12:0] quot;
    logic [12:0]        rem;
    logic               round_up;
    logic signed [13:0] rounded;
    logic [7:0]         tone_next;

    // Product (2v - 255) * gain.
    always_comb begin
        centered  = $signed({1'b0, value, 1'b0}) - 10'sd255;
        prod_next = 21'(centered) * 21'($signed({1'b0, contrast_gain}));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
        end
    end

    // Scale to /8192, add the mid level and offset, round half to even, clamp.
    always_comb begin
        num      = (26'(prod_reg) <<< 4) + 26'sd1044480 + (26'(brightness_offset) <<< 9);
        quot     = num[25:13];
        rem      = num[12:0];
        round_up = (rem > 13'h1000) || ((rem == 13'h1000) && quot[0]);
        rounded  = $signed({quot[12], quot}) + $signed({13'd0, round_up});
        if (rounded < 14'sd0) begin
            tone_next = 8'd0;
        end else if (rounded > 14'sd255) begin
            tone_next = 8'd255;
        end else begin
            tone_next = rounded[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tone_reg <= tone_next;
        end
    end

endmodule

>>> src/ptst_sat_lane.sv
// ----------------------------------------------------------------------------
// ptst_sat_lane
// Saturation for one channel: a registered multiply of the factor by the
// distance from luma, then a registered round-half-even and clamp.
// ----------------------------------------------------------------------------
module ptst_sat_lane (
    input  logic       aclk,
    input  logic       advance,
    input  logic [7:0] value,
    input  logic [7:0] luma_value,
    input  logic [9:0] saturation_factor,
    output logic [7:0] sat_reg
);

    logic signed [9:0]  diff;
    logic signed [20:0] prod_next;
    logic signed [20:0] prod_reg;
    logic [7:0]         luma_reg;
    logic signed [21:0] num;
    logic signed [13:0] quot;
    logic [7:0]         rem;
    logic               round_up;
    logic signed [14:0] rounded;
    logic [7:0]         sat_next;

    // Product f * (v - Y); luma travels alongside.
    always_comb begin
        diff      = $signed({2'b00, value}) - $signed({2'b00, luma_value});
        prod_next = 21'(diff) * 21'($signed({1'b0, saturation_factor}));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            luma_reg <= luma_value;
        end
    end

    // Add Y * 256, divide by 256 with round half to even, clamp.
    always_comb begin
        num      = 22'(prod_reg) + $signed({6'd0, luma_reg, 8'd0});
        quot     = num[21:8];
        rem      = num[7:0];
        round_up = (rem > 8'h80) || ((rem == 8'h80) && quot[0]);
        rounded  = $signed({quot[13], quot}) + $signed({14'd0, round_up});
        if (rounded < 15'sd0) begin
            sat_next = 8'd0;
        end else if (rounded > 15'sd255) begin
            sat_next = 8'd255;
        end else begin
            sat_next = rounded[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sat_reg <= sat_next;
        end
    end

endmodule

>>> src/ptst_luma_merge.sv
// ----------------------------------------------------------------------------
// ptst_luma_merge
// Merging stage: collects the three lane results into one pixel and
// registers it together with its luma.
// ----------------------------------------------------------------------------
module ptst_luma_merge (
    input  logic          aclk,
    input  logic          advance,
    input  ptst_pkg::pix_t pixel,
    output ptst_pkg::pix_t pixel_reg,
    output logic [7:0]    luma_reg
);

    always_ff @(posedge aclk) begin
        if (advance) begin
            pixel_reg <= pixel;
            luma_reg  <= ptst_pkg::luma(pixel);
        end
    end

endmodule

>>> src/ptst_checker.sv
// ----------------------------------------------------------------------------
// ptst_checker
// Port-level checks of the pixel tone, saturation and threshold core,
// attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "pixel_tone_saturation_threshold_core_macros.svh"

module ptst_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ptst_pkg::pixel_out_t m_data
);

    // A waiting result stays and holds its value.
    `PTST_ASSERT_ON(a_result_holds, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

    // Reset empties the pipeline.
    `PTST_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid)

    // The input never stalls while the consumer is taking items.
    `PTST_ASSERT_ON(a_ready_when_drained, aclk, aresetn, m_ready |-> s_ready)

    // With the output register empty the block always takes an item.
    `PTST_ASSERT_ON(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready)

endmodule

bind pixel_tone_saturation_threshold_core ptst_checker u_ptst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
